### hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; take it in with `include "assert_macros.svh".
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked on the rising edge, off while reset is low.
`define OSDT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: antecedent |-> consequent.
`define OSDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication form: antecedent |=> consequent.
`define OSDT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/osdt_pkg.sv
// Shared types and constants of the one-shot deadline timer.
// No dependencies; used by the timer, its checker and the testbench.
`default_nettype none

package osdt_pkg;

  // Widths of millisecond time values, the minimum-delay register and command codes
  localparam int unsigned TimeW  = 48;
  localparam int unsigned DelayW = 32;
  localparam int unsigned CmdW   = 3;

  // Command codes carried by each input item
  typedef enum logic [CmdW-1:0] {
    CMD_TICK           = 3'd0,
    CMD_SET            = 3'd1,
    CMD_SET_EARLIER    = 3'd2,
    CMD_CANCEL         = 3'd3,
    CMD_SET_NOT_BEFORE = 3'd4,
    CMD_ENABLE         = 3'd5,
    CMD_DISABLE        = 3'd6
  } cmd_e;

  typedef logic [TimeW-1:0] time_t;

endpackage

`default_nettype wire

### hdl/one_shot_deadline_timer.sv
// An input transfer reaches its result through the input register, then
// the result register that also updates the state.
// Throughput: one item per cycle; the input stalls only while both the
// input register and the result register are full and the result is held.
// Reset (async, active low): time, deadline, floor, enable and minimum lead
// clear to zero; both pipeline registers come up empty.
`default_nettype none

module one_shot_deadline_timer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration: minimum lead time
  input  wire logic                          cfg_we_i,
  input  wire logic [osdt_pkg::DelayW-1:0]   cfg_wdata_i,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [osdt_pkg::CmdW-1:0]     command_i,
  input  wire logic [osdt_pkg::TimeW-1:0]    time_value_i,
  input  wire logic                          relative_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               fired_o,
  output logic                               pending_o,
  output logic [osdt_pkg::TimeW-1:0]         deadline_out_o,
  output logic [osdt_pkg::TimeW-1:0]         current_time_o
);

  localparam osdt_pkg::time_t TimeMax = '1;

  // saturating add of two time values
  function automatic osdt_pkg::time_t sat_add(osdt_pkg::time_t a, osdt_pkg::time_t b);
    logic [osdt_pkg::TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[osdt_pkg::TimeW] ? TimeMax : s[osdt_pkg::TimeW-1:0];
  endfunction

  // configuration register
  logic [osdt_pkg::DelayW-1:0] min_lead_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lead_q <= '0;
    end else if (cfg_we_i) begin
      min_lead_q <= cfg_wdata_i;
    end
  end

  // input register
  logic                  s1_valid_q;
  osdt_pkg::cmd_e        s1_cmd_q;
  osdt_pkg::time_t       s1_time_q;
  logic                  s1_rel_q;
  logic                  advance;

  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_cmd_q  <= osdt_pkg::cmd_e'(command_i);
      s1_time_q <= time_value_i;
      s1_rel_q  <= relative_i;
    end
  end

  // timer state
  osdt_pkg::time_t now_q, now_d;
  osdt_pkg::time_t deadline_q, deadline_d;
  osdt_pkg::time_t floor_q, floor_d;
  logic            dl_valid_q, dl_valid_d;
  logic            enabled_q, enabled_d;
  logic            fired_d;

  // request clamping and next state
  osdt_pkg::time_t min_ext, rel_off, rel_t, earliest, abs_t, req_t;
  osdt_pkg::time_t now_inc, eff_t;

  always_comb begin
    min_ext  = {{(osdt_pkg::TimeW-osdt_pkg::DelayW){1'b0}}, min_lead_q};
    rel_off  = (s1_time_q < min_ext) ? min_ext : s1_time_q;
    rel_t    = sat_add(rel_off, now_q);
    earliest = sat_add(now_q, min_ext);
    abs_t    = (s1_time_q < earliest) ? earliest : s1_time_q;
    req_t    = s1_rel_q ? rel_t : abs_t;
    now_inc  = (now_q == TimeMax) ? now_q : now_q + osdt_pkg::time_t'(1);
    eff_t    = (deadline_q < floor_q) ? floor_q : deadline_q;
  end

  always_comb begin
    now_d      = now_q;
    deadline_d = deadline_q;
    floor_d    = floor_q;
    dl_valid_d = dl_valid_q;
    enabled_d  = enabled_q;
    fired_d    = 1'b0;
    case (s1_cmd_q)
      osdt_pkg::CMD_TICK: begin
        now_d = now_inc;
        if (enabled_q && dl_valid_q && (now_inc >= eff_t)) begin
          fired_d    = 1'b1;
          dl_valid_d = 1'b0;
          deadline_d = '0;
        end
      end
      osdt_pkg::CMD_SET: begin
        deadline_d = req_t;
        dl_valid_d = 1'b1;
      end
      osdt_pkg::CMD_SET_EARLIER: begin
        if (!dl_valid_q || (deadline_q > req_t)) begin
          deadline_d = req_t;
          dl_valid_d = 1'b1;
        end
      end
      osdt_pkg::CMD_CANCEL: begin
        dl_valid_d = 1'b0;
        deadline_d = '0;
      end
      osdt_pkg::CMD_SET_NOT_BEFORE: begin
        floor_d = s1_rel_q ? sat_add(s1_time_q, now_q) : s1_time_q;
      end
      osdt_pkg::CMD_ENABLE:  enabled_d = 1'b1;
      osdt_pkg::CMD_DISABLE: enabled_d = 1'b0;
      default: ;
    endcase
  end

  // state and result update, once per item leaving the input register
  logic do_step;
  assign do_step = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q      <= '0;
      deadline_q <= '0;
      floor_q    <= '0;
      dl_valid_q <= 1'b0;
      enabled_q  <= 1'b0;
    end else if (do_step) begin
      now_q      <= now_d;
      deadline_q <= deadline_d;
      floor_q    <= floor_d;
      dl_valid_q <= dl_valid_d;
      enabled_q  <= enabled_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      fired_o        <= fired_d;
      pending_o      <= dl_valid_d;
      deadline_out_o <= dl_valid_d ? deadline_d : '0;
      current_time_o <= now_d;
    end
  end

endmodule

`default_nettype wire

### hdl/osdt_checker.sv
// Port-level checker for the one-shot deadline timer, bound to the top level.
// Depends on osdt_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module osdt_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic                        fired_o,
  input wire logic                        pending_o,
  input wire logic [osdt_pkg::TimeW-1:0]  deadline_out_o,
  input wire logic [osdt_pkg::TimeW-1:0]  current_time_o
);

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // items accepted but not yet delivered
  logic [2:0] inflight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + {2'b0, in_xfer} - {2'b0, out_xfer};
    end
  end

  // time reported by the last delivered result
  logic                   seen_q;
  osdt_pkg::time_t        last_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_time_q <= '0;
    end else if (out_xfer) begin
      seen_q      <= 1'b1;
      last_time_q <= current_time_o;
    end
  end

  // a held result keeps its payload
  `OSDT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(current_time_o) && $stable(deadline_out_o) && $stable(fired_o) && $stable(pending_o), "result changed while stalled")

  // input only stalls behind a held result
  `OSDT_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i, "input stalled without output backpressure")

  // at most two items in the block
  `OSDT_ASSERT(a_inflight, clk_i, rst_ni, inflight_q <= 3'd2, "more than two items in flight")

  // the time counter never runs backwards between results
  `OSDT_ASSERT_IMP(a_time_mono, clk_i, rst_ni, out_valid_o && seen_q, current_time_o >= last_time_q, "current_time decreased")

endmodule

bind one_shot_deadline_timer osdt_checker u_osdt_checker (.*);

`default_nettype wire

### verif/tb_one_shot_deadline_timer.sv
// Self-checking testbench for one_shot_deadline_timer: directed and random commands with
// random idling on both handshakes, checked against an in-bench timer model.
// Depends on osdt_pkg and the timer RTL only.

module tb_one_shot_deadline_timer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [osdt_pkg::CmdW-1:0] CMD_RESERVED = 3'd7;
  localparam osdt_pkg::time_t TIME_MAX = '1;
  localparam int unsigned PHASES = 7;
  localparam int unsigned PHASE_ITEMS = 225;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 500000;

  // Expected status after one item
  typedef struct packed {
    logic            fired;
    logic            pending;
    osdt_pkg::time_t due;
    osdt_pkg::time_t now_ms;
  } status_t;

  // Timer model plus the queue of status items still to come out
  class timer_status_board;
    osdt_pkg::time_t now_ms = '0;
    osdt_pkg::time_t due_ms = '0;
    osdt_pkg::time_t floor_ms = '0;
    bit due_set = 1'b0;
    bit armed = 1'b0;
    logic [osdt_pkg::DelayW-1:0] min_gap = '0;
    status_t awaited[$];
    int unsigned checked = 0;
    int unsigned fires = 0;
    int unsigned mismatches = 0;

    function osdt_pkg::time_t sat_sum(osdt_pkg::time_t a, osdt_pkg::time_t b);
      logic [osdt_pkg::TimeW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[osdt_pkg::TimeW] ? TIME_MAX : s[osdt_pkg::TimeW-1:0];
    endfunction

    // Requested deadline pushed out to at least min_gap past now
    function osdt_pkg::time_t clamp_request(osdt_pkg::time_t t, logic rel);
      osdt_pkg::time_t earliest;
      if (rel) begin
        if (t < osdt_pkg::time_t'(min_gap)) t = osdt_pkg::time_t'(min_gap);
        return sat_sum(t, now_ms);
      end
      earliest = sat_sum(now_ms, osdt_pkg::time_t'(min_gap));
      return (t < earliest) ? earliest : t;
    endfunction

    function void note_command(logic [osdt_pkg::CmdW-1:0] cmd, osdt_pkg::time_t tv,
                               logic rel);
      status_t s;
      osdt_pkg::time_t t;
      osdt_pkg::time_t eff;
      s = '0;
      case (cmd)
        osdt_pkg::CMD_TICK: begin
          now_ms = sat_sum(now_ms, osdt_pkg::time_t'(1));
          eff = (due_ms < floor_ms) ? floor_ms : due_ms;
          if (armed && due_set && now_ms >= eff) begin
            s.fired = 1'b1;
            due_set = 1'b0;
            due_ms = '0;
          end
        end
        osdt_pkg::CMD_SET: begin
          due_ms = clamp_request(tv, rel);
          due_set = 1'b1;
        end
        osdt_pkg::CMD_SET_EARLIER: begin
          t = clamp_request(tv, rel);
          if (!due_set || due_ms > t) begin
            due_ms = t;
            due_set = 1'b1;
          end
        end
        osdt_pkg::CMD_CANCEL: begin
          due_set = 1'b0;
          due_ms = '0;
        end
        // floor is never clamped by min_gap
        osdt_pkg::CMD_SET_NOT_BEFORE: floor_ms = rel ? sat_sum(tv, now_ms) : tv;
        osdt_pkg::CMD_ENABLE: armed = 1'b1;
        osdt_pkg::CMD_DISABLE: armed = 1'b0;
        default: ;  // reserved code leaves the state alone
      endcase
      s.pending = due_set;
      s.due = due_set ? due_ms : '0;
      s.now_ms = now_ms;
      awaited.push_back(s);
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH %s", msg);
    endfunction

    function void check_status(logic fired, logic pending, osdt_pkg::time_t due,
                               osdt_pkg::time_t now_ms);
      status_t want;
      if (awaited.size() == 0) begin
        note_failure($sformatf("unexpected result: fired=%0b pending=%0b deadline=%0h time=%0h",
                               fired, pending, due, now_ms));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (want.fired) fires++;
      if (fired !== want.fired || pending !== want.pending || due !== want.due ||
          now_ms !== want.now_ms)
        note_failure($sformatf({"result %0d (exp/act): fired %0b/%0b pending %0b/%0b ",
                                "deadline %0h/%0h time %0h/%0h"}, checked,
                               want.fired, fired, want.pending, pending,
                               want.due, due, want.now_ms, now_ms));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [osdt_pkg::DelayW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [osdt_pkg::CmdW-1:0] command_i = osdt_pkg::CMD_TICK;
  osdt_pkg::time_t time_value_i = '0;
  logic relative_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic fired_o;
  logic pending_o;
  osdt_pkg::time_t deadline_out_o;
  osdt_pkg::time_t current_time_o;

  timer_status_board board = new;

  bit sender_gaps_on = 1'b1;
  bit receiver_stalls_on = 1'b1;
  bit hold_off_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned deadline_runs = 0;
  int unsigned input_stalls = 0;
  int unsigned hold_offs = 0;
  int unsigned cycles = 0;

  one_shot_deadline_timer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .time_value_i   (time_value_i),
    .relative_i     (relative_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .fired_o        (fired_o),
    .pending_o      (pending_o),
    .deadline_out_o (deadline_out_o),
    .current_time_o (current_time_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycles,
               board.awaited.size());
      $display("** one_shot_deadline_timer: FAILED **");
      $finish;
    end
  end

  // Transfer monitor: results are checked before this edge's input is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        board.check_status(fired_o, pending_o, deadline_out_o, current_time_o);
      if (in_valid_i && in_ready_o)
        board.note_command(command_i, time_value_i, relative_i);
      else if (in_valid_i)
        input_stalls++;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic osdt_pkg::time_t full_random_time();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Result receiver; a requested hold-off keeps ready low for a long stretch
  initial begin
    int unsigned n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        hold_offs++;
      end else begin
        n = idle_length();
        if (!receiver_stalls_on || n == 0) begin
          out_ready_i <= 1'b1;
          @(posedge clk_i);
        end else begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  function automatic logic [osdt_pkg::CmdW-1:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 42) return osdt_pkg::CMD_TICK;
    if (r < 55) return osdt_pkg::CMD_SET;
    if (r < 66) return osdt_pkg::CMD_SET_EARLIER;
    if (r < 70) return osdt_pkg::CMD_CANCEL;
    if (r < 78) return osdt_pkg::CMD_SET_NOT_BEFORE;
    if (r < 90) return osdt_pkg::CMD_ENABLE;
    if (r < 97) return osdt_pkg::CMD_DISABLE;
    return CMD_RESERVED;
  endfunction

  // Mostly times near now so deadlines actually fire
  function automatic osdt_pkg::time_t pick_time(logic rel);
    int unsigned r;
    osdt_pkg::time_t around;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 15) return TIME_MAX - osdt_pkg::time_t'($urandom_range(0, 3));
    if (r < 30) return full_random_time();
    if (rel) return osdt_pkg::time_t'($urandom_range(0, 12));
    around = board.now_ms + osdt_pkg::time_t'($urandom_range(0, 12));
    return (around >= osdt_pkg::time_t'(3)) ? around - osdt_pkg::time_t'(3) : around;
  endfunction

  // One input transfer, then an optional gap
  task automatic send_item(logic [osdt_pkg::CmdW-1:0] cmd, osdt_pkg::time_t tv, logic rel);
    int unsigned gap;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    time_value_i <= tv;
    relative_i <= rel;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    gap = idle_length();
    if (sender_gaps_on && gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_item();
    logic [osdt_pkg::CmdW-1:0] cmd;
    logic rel;
    osdt_pkg::time_t tv;
    cmd = pick_command();
    rel = 1'($urandom_range(0, 1));
    tv = pick_time(rel);
    // pull the floor back down often, or nothing fires for long
    if (cmd == osdt_pkg::CMD_SET_NOT_BEFORE && $urandom_range(0, 2) == 0) begin
      rel = 1'b0;
      tv = '0;
    end
    send_item(cmd, tv, rel);
  endtask

  // Arm, set a near deadline, then tick toward it with some noise mixed in
  task automatic send_deadline_run();
    int unsigned ticks;
    deadline_runs++;
    if (!board.armed)
      send_item(osdt_pkg::CMD_ENABLE, full_random_time(), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0)
      send_item(osdt_pkg::CMD_SET_NOT_BEFORE, osdt_pkg::time_t'($urandom_range(0, 6)), 1'b1);
    send_item($urandom_range(0, 1) ? osdt_pkg::CMD_SET : osdt_pkg::CMD_SET_EARLIER,
              osdt_pkg::time_t'($urandom_range(0, 10)), 1'b1);
    ticks = $urandom_range(1, 14);
    repeat (ticks) begin
      if ($urandom_range(0, 9) == 0) send_random_item();
      else send_item(osdt_pkg::CMD_TICK, full_random_time(), 1'($urandom_range(0, 1)));
    end
  endtask

  // Wait until every result is out and the pipeline has emptied
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_min_lead(logic [osdt_pkg::DelayW-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.min_gap = value;
  endtask

  initial begin
    logic [osdt_pkg::DelayW-1:0] gap_value;
    int unsigned phase_end;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, minimum lead still at its reset value of zero
    send_item(osdt_pkg::CMD_TICK, '0, 1'b0);                   // disabled, nothing stored
    send_item(CMD_RESERVED, TIME_MAX, 1'b1);                   // reserved code
    send_item(osdt_pkg::CMD_SET, '0, 1'b0);                    // absolute time in the past
    send_item(osdt_pkg::CMD_ENABLE, '0, 1'b0);
    send_item(osdt_pkg::CMD_TICK, '0, 1'b0);                   // fires
    send_item(osdt_pkg::CMD_SET, 48'd3, 1'b1);
    send_item(osdt_pkg::CMD_SET_EARLIER, 48'd10, 1'b1);        // later, ignored
    send_item(osdt_pkg::CMD_SET_EARLIER, 48'd4, 1'b0);         // sooner, taken
    send_item(osdt_pkg::CMD_SET_NOT_BEFORE, 48'd5, 1'b1);      // floor delays the fire
    repeat (5) send_item(osdt_pkg::CMD_TICK, 48'hAAAA_AAAA_AAAA, 1'b1);
    send_item(osdt_pkg::CMD_ENABLE, 48'h5555_5555_5555, 1'b0); // repeated enable
    send_item(osdt_pkg::CMD_SET, TIME_MAX, 1'b1);              // relative sum saturates
    send_item(osdt_pkg::CMD_SET_EARLIER, TIME_MAX, 1'b0);      // equal, not sooner
    send_item(osdt_pkg::CMD_DISABLE, '0, 1'b0);
    send_item(osdt_pkg::CMD_DISABLE, '0, 1'b0);
    send_item(osdt_pkg::CMD_SET_NOT_BEFORE, '0, 1'b0);
    send_item(osdt_pkg::CMD_CANCEL, '0, 1'b0);
    send_item(osdt_pkg::CMD_SET_EARLIER, '0, 1'b1);            // nothing pending: taken
    send_item(osdt_pkg::CMD_TICK, '0, 1'b0);                   // disabled: held
    send_item(osdt_pkg::CMD_ENABLE, '0, 1'b0);
    send_item(osdt_pkg::CMD_TICK, '0, 1'b0);                   // fires after enable
    send_item(osdt_pkg::CMD_SET_NOT_BEFORE, TIME_MAX, 1'b0);   // floor at the top
    send_item(osdt_pkg::CMD_SET, '0, 1'b1);
    send_item(osdt_pkg::CMD_TICK, '0, 1'b0);                   // blocked by floor
    send_item(osdt_pkg::CMD_CANCEL, '0, 1'b0);
    send_item(osdt_pkg::CMD_SET_NOT_BEFORE, '0, 1'b0);

    // Random phases, each under its own minimum lead
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: gap_value = '0;
        1: gap_value = 32'd1;
        2: gap_value = '1;
        3: gap_value = 32'd5;
        4: gap_value = $urandom_range(0, 15);
        5: gap_value = $urandom;
        default: gap_value = 32'd2;
      endcase
      drain();
      write_min_lead(gap_value);
      sender_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      receiver_stalls_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      // long receiver hold-off while the sender keeps offering
      if (phase == 1 || phase == 4) begin
        sender_gaps_on = 1'b0;
        hold_off_req = 1'b1;
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 1) != 0) send_deadline_run();
        else send_random_item();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);

    $display("Run sent %0d items (%0d deadline runs) over %0d minimum-lead settings,",
             items_sent, deadline_runs, PHASES);
    $display("zero and max among them; checked %0d results, %0d fires, %0d stall cycles,",
             board.checked, board.fires, input_stalls);
    $display("%0d hold-offs, %0d mismatches.", hold_offs, board.mismatches);
    if (board.mismatches == 0 && board.awaited.size() == 0) begin
      $display("** one_shot_deadline_timer: PASSED **");
    end else begin
      $display("** one_shot_deadline_timer: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/osdt_pkg.sv
hdl/one_shot_deadline_timer.sv
hdl/osdt_checker.sv
verif/tb_one_shot_deadline_timer.sv
